// ----- rtl/core/agb_pkg.sv -----
// ============================================================================
// agb_pkg
// Shared types and constants of the adaptive gamma binarizer.
// ============================================================================
`default_nettype none

package agb_pkg;

    // Widths of the fields and registers.
    localparam int VALUE_W = 16;
    localparam int CNT_W   = 16;
    localparam int INC_W   = 8;
    localparam int NORM_W  = 16;
    localparam int INIT_W  = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    // Register indexes on the configuration port (paddr[3:2]).
    localparam logic [1:0] REG_INCREMENT = 2'd0;
    localparam logic [1:0] REG_NORM      = 2'd1;
    localparam logic [1:0] REG_INIT      = 2'd2;

    // Decision queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Flags that travel with each decision.
    typedef struct packed {
        logic dbit;
        logic last;
        logic err;
    } dec_flags_t;

    localparam int FLAGS_W = $bits(dec_flags_t);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SIGN = 4'b0010,
        F_LEN  = 4'b0100,
        F_SUF  = 4'b1000
    } front_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/adaptive_gamma_binarizer.sv -----
// ============================================================================
// adaptive_gamma_binarizer
// The first decision of a value passes the front state register, the decision
// queue, the update stage and the output register.
// The front takes no new value until it has pushed the last decision of the
// current one; an out-of-range value gives a single flagged decision. The back
// retires one decision per cycle from the context RAM while the output is not
// stalled, forwarding back-to-back writes. Reset: counts clear; a clearing
// pass then marks every context fresh, and no value is taken until it ends.
// ============================================================================
`default_nettype none

module adaptive_gamma_binarizer
    import agb_pkg::*;
#(
    parameter int MAX_LEN  = 8,
    parameter int CONTEXTS = 2048
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // Configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic        [APB_AW-1:0]  paddr,
    input  wire logic        [APB_DW-1:0]  pwdata,
    output logic             [APB_DW-1:0]  prdata,
    output logic                           pready,

    // Value channel
    input  wire logic                      value_valid,
    output logic                           value_stall,
    input  wire logic signed [VALUE_W-1:0] value,

    // Decision channel
    output logic                           decision_valid,
    input  wire logic                      decision_stall,
    output logic                           decision_bit,
    output logic             [CNT_W-1:0]   zero_count,
    output logic             [CNT_W-1:0]   one_count,
    output logic                           last_decision,
    output logic                           range_error
);

    localparam int IW = $clog2(CONTEXTS);
    localparam int QW = FLAGS_W + IW;

    logic [INC_W-1:0]  inc_reg;
    logic [NORM_W-1:0] norm_reg;
    logic [INIT_W-1:0] init_reg;

    logic       cfg_write;
    logic [1:0] reg_sel;

    logic          clearing;
    logic          push;
    logic          push_full;
    dec_flags_t    push_flags;
    logic [IW-1:0] push_idx;
    logic          q_vld;
    logic          pop;
    logic [QW-1:0] q_data;
    dec_flags_t    q_flags;
    logic [IW-1:0] q_idx;

    // ------------------------------------------------------------------
    // Configuration registers: write on the access phase, no wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg  <= INC_W'(1);
            norm_reg <= NORM_W'(256);
            init_reg <= INIT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_INCREMENT: inc_reg  <= pwdata[INC_W-1:0];
                REG_NORM:      norm_reg <= pwdata[NORM_W-1:0];
                REG_INIT:      init_reg <= pwdata[INIT_W-1:0];
                default:       ;  // drop writes to unmapped addresses
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb
    begin
        unique case (reg_sel)
            REG_INCREMENT: prdata = APB_DW'(inc_reg);
            REG_NORM:      prdata = APB_DW'(norm_reg);
            REG_INIT:      prdata = APB_DW'(init_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: classify the value and emit its decisions with context index.
    // ------------------------------------------------------------------
    agb_front #(
        .MAX_LEN  (MAX_LEN),
        .CONTEXTS (CONTEXTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .clearing    (clearing),
        .push_full   (push_full),
        .push        (push),
        .push_flags  (push_flags),
        .push_idx    (push_idx)
    );

    // ------------------------------------------------------------------
    // Decision queue: lets the front run ahead while the output stalls.
    // ------------------------------------------------------------------
    agb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_flags, push_idx}),
        .full      (push_full),
        .pop       (pop),
        .vld       (q_vld),
        .data      (q_data)
    );

    assign q_flags = q_data[QW-1:IW];
    assign q_idx   = q_data[IW-1:0];

    // ------------------------------------------------------------------
    // Back: context update and result register.
    // ------------------------------------------------------------------
    agb_back #(
        .CONTEXTS (CONTEXTS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .count_increment (inc_reg),
        .norm_limit      (norm_reg),
        .initial_count   (init_reg),
        .q_vld           (q_vld),
        .q_flags         (q_flags),
        .q_idx           (q_idx),
        .pop             (pop),
        .clearing        (clearing),
        .decision_valid  (decision_valid),
        .decision_stall  (decision_stall),
        .decision_bit    (decision_bit),
        .zero_count      (zero_count),
        .one_count       (one_count),
        .last_decision   (last_decision),
        .range_error     (range_error)
    );

endmodule

`default_nettype wire

// ----- rtl/core/agb_ram.sv -----
// ============================================================================
// agb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
`default_nettype none

module agb_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/agb_queue.sv -----
// ============================================================================
// agb_queue
// Short register FIFO that decouples the decision front from the back.
// ============================================================================
`default_nettype none

module agb_queue
    import agb_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  vld,
    output logic      [WIDTH-1:0] data
);

    logic [WIDTH-1:0]       slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] head_reg, head_next;
    logic [QUEUE_PTR_W-1:0] tail_reg, tail_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign full = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign vld  = (cnt_reg != '0);
    assign data = slot_reg[head_reg];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            tail_next = tail_reg + QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            head_next = head_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/agb_front.sv -----
// ============================================================================
// agb_front
// Accepts a value, classifies it and walks its decisions, one per cycle while
// the queue has room, pushing decision bit, flags and context index into the queue.
// ============================================================================
`default_nettype none

module agb_front
    import agb_pkg::*;
#(
    parameter int MAX_LEN  = 8,
    parameter int CONTEXTS = 2048,
    localparam int IW      = $clog2(CONTEXTS),
    localparam int LW      = $clog2(MAX_LEN + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      value_valid,
    output logic                           value_stall,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      clearing,
    input  wire logic                      push_full,
    output logic                           push,
    output dec_flags_t                     push_flags,
    output logic             [IW-1:0]      push_idx
);

    localparam int                MAG_W  = VALUE_W - 1;
    localparam int                STP_W  = IW + 3;
    localparam logic [STP_W-1:0]  C_ONE  = STP_W'(CONTEXTS);
    localparam logic [STP_W-1:0]  C_TWO  = STP_W'(2 * CONTEXTS);

    front_state_t       state_reg, state_next;
    logic               sgn_reg, sgn_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               err_reg, err_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      k_reg, k_next;
    logic [LW-1:0]      rem_reg, rem_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      sbm_reg, sbm_next;
    logic [MAX_LEN-1:0] suf_reg, suf_next;

    logic               sgn_in;
    logic [MAG_W-1:0]   mag_in;
    logic [VALUE_W-1:0] t_in;
    logic [3:0]         len_in;
    logic [MAG_W-1:0]   enc_full;
    logic [MAX_LEN-1:0] enc_aligned;
    logic [STP_W-1:0]   stp;
    logic [IW-1:0]      suf_idx_next;
    logic [IW-1:0]      len_idx_next;

    // Context index tables, reduced modulo the store depth at elaboration.
    logic [IW-1:0] base_tab [2];
    logic [IW-1:0] sufb_tab [2][MAX_LEN + 1];

    genvar gs, gl;
    generate
        for (gs = 0; gs < 2; gs++)
        begin : g_sign
            localparam int BASE = 1 + gs * ((1 << (MAX_LEN + 1)) - 1);
            assign base_tab[gs] = IW'(BASE % CONTEXTS);
            for (gl = 0; gl <= MAX_LEN; gl++)
            begin : g_len
                localparam int SUFB = BASE + MAX_LEN + 1 + (1 << gl) - 1 - gl;
                assign sufb_tab[gs][gl] = IW'(SUFB % CONTEXTS);
            end
        end
    endgenerate

    assign value_stall = (state_reg != F_IDLE) || clearing;

    // Classify: sign, magnitude and prefix length of the incoming value.
    always_comb
    begin
        sgn_in = value[VALUE_W-1];
        mag_in = sgn_in ? ~value[MAG_W-1:0] : value[MAG_W-1:0];
        t_in   = {1'b0, mag_in} + VALUE_W'(1);
        len_in = '0;
        for (int i = 0; i < VALUE_W; i++)
        begin
            if (t_in[i])
            begin
                len_in = 4'(i);
            end
        end
    end

    // Suffix bits, left aligned so the next one is always the top bit.
    always_comb
    begin
        enc_full    = mag_reg - ((MAG_W'(1) << len_reg) - MAG_W'(1));
        enc_aligned = enc_full[MAX_LEN-1:0] << (LW'(MAX_LEN) - len_reg);
    end

    // Next suffix node: 2*idx + 1 + bit - sufbase, brought back into range.
    always_comb
    begin
        stp = {2'b00, idx_reg, 1'b0} + STP_W'(1) + STP_W'(suf_reg[MAX_LEN-1])
              - {3'b000, sbm_reg};
        if (stp[STP_W-1])
        begin
            suf_idx_next = IW'(stp + C_ONE);
        end
        else if (stp >= C_TWO)
        begin
            suf_idx_next = IW'(stp - C_TWO);
        end
        else if (stp >= C_ONE)
        begin
            suf_idx_next = IW'(stp - C_ONE);
        end
        else
        begin
            suf_idx_next = IW'(stp);
        end
    end

    assign len_idx_next = (idx_reg == IW'(CONTEXTS - 1)) ? '0 : idx_reg + IW'(1);

    always_comb
    begin
        state_next = state_reg;
        sgn_next   = sgn_reg;
        mag_next   = mag_reg;
        err_next   = err_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        sbm_next   = sbm_reg;
        suf_next   = suf_reg;
        push       = 1'b0;
        push_flags = '0;
        push_idx   = idx_reg;

        unique case (state_reg)
            F_IDLE:
            begin
                if (value_valid && !value_stall)
                begin
                    sgn_next   = sgn_in;
                    mag_next   = mag_in;
                    err_next   = (len_in > 4'(MAX_LEN));
                    len_next   = LW'(len_in);
                    state_next = F_SIGN;
                end
            end
            F_SIGN:
            begin
                if (!push_full)
                begin
                    push     = 1'b1;
                    push_idx = '0;
                    if (err_reg)
                    begin
                        push_flags = '{dbit: 1'b0, last: 1'b1, err: 1'b1};
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        push_flags = '{dbit: sgn_reg, last: 1'b0, err: 1'b0};
                        idx_next   = base_tab[sgn_reg];
                        k_next     = '0;
                        suf_next   = enc_aligned;
                        state_next = F_LEN;
                    end
                end
            end
            F_LEN:
            begin
                if (!push_full)
                begin
                    push = 1'b1;
                    if (k_reg == len_reg)
                    begin
                        push_flags = '{dbit: 1'b1, last: (len_reg == '0), err: 1'b0};
                        idx_next   = sufb_tab[sgn_reg][len_reg];
                        sbm_next   = sufb_tab[sgn_reg][len_reg];
                        rem_next   = len_reg;
                        state_next = (len_reg == '0) ? F_IDLE : F_SUF;
                    end
                    else
                    begin
                        push_flags = '{dbit: 1'b0, last: 1'b0, err: 1'b0};
                        idx_next   = len_idx_next;
                        k_next     = k_reg + LW'(1);
                    end
                end
            end
            F_SUF:
            begin
                if (!push_full)
                begin
                    push       = 1'b1;
                    push_flags = '{dbit: suf_reg[MAX_LEN-1], last: (rem_reg == LW'(1)),
                                   err: 1'b0};
                    idx_next   = suf_idx_next;
                    suf_next   = suf_reg << 1;
                    rem_next   = rem_reg - LW'(1);
                    if (rem_reg == LW'(1))
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sgn_reg <= sgn_next;
        mag_reg <= mag_next;
        err_reg <= err_next;
        len_reg <= len_next;
        k_reg   <= k_next;
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        sbm_reg <= sbm_next;
        suf_reg <= suf_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/agb_back.sv -----
// ============================================================================
// agb_back
// Context read-modify-write pipeline: read stage, update stage with
// forwarding, output register; also runs the clearing pass after reset.
// ============================================================================
`default_nettype none

module agb_back
    import agb_pkg::*;
#(
    parameter int CONTEXTS = 2048,
    localparam int IW      = $clog2(CONTEXTS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [INC_W-1:0]  count_increment,
    input  wire logic [NORM_W-1:0] norm_limit,
    input  wire logic [INIT_W-1:0] initial_count,
    input  wire logic              q_vld,
    input  wire dec_flags_t        q_flags,
    input  wire logic [IW-1:0]     q_idx,
    output logic                   pop,
    output logic                   clearing,
    output logic                   decision_valid,
    input  wire logic              decision_stall,
    output logic                   decision_bit,
    output logic      [CNT_W-1:0]  zero_count,
    output logic      [CNT_W-1:0]  one_count,
    output logic                   last_decision,
    output logic                   range_error
);

    localparam int WORD_W = 2 * CNT_W + 1;

    // Clearing pass
    logic          clr_reg;
    logic [IW-1:0] clr_cnt_reg;

    // Update stage
    logic              b_vld_reg;
    dec_flags_t        b_flags_reg;
    logic [IW-1:0]     b_idx_reg;
    logic              byp_hit_reg;
    logic [2*CNT_W-1:0] byp_data_reg;

    // Output register
    logic out_vld_reg;

    logic               b_fire;
    logic               a_fire;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;
    logic [2*CNT_W-1:0] cur;
    logic [CNT_W-1:0]   cur_z, cur_o;
    logic [CNT_W:0]     z_add, o_add;
    logic [CNT_W+1:0]   sum;
    logic               halve;
    logic [CNT_W-1:0]   z_new, o_new;
    logic [2*CNT_W-1:0] new_word;

    assign clearing       = clr_reg;
    assign decision_valid = out_vld_reg;

    assign b_fire = b_vld_reg && (!out_vld_reg || !decision_stall);
    assign a_fire = q_vld && !clr_reg && (!b_vld_reg || b_fire);
    assign pop    = a_fire;

    // Current counts: forwarded, stored, or fresh.
    always_comb
    begin
        if (byp_hit_reg)
        begin
            cur = byp_data_reg;
        end
        else if (ram_rdata[WORD_W-1])
        begin
            cur = ram_rdata[2*CNT_W-1:0];
        end
        else
        begin
            cur = {CNT_W'(initial_count), CNT_W'(initial_count)};
        end
        cur_z = cur[CNT_W-1:0];
        cur_o = cur[2*CNT_W-1:CNT_W];
        z_add = {1'b0, cur_z} + (b_flags_reg.dbit ? '0 : (CNT_W+1)'(count_increment));
        o_add = {1'b0, cur_o} + (b_flags_reg.dbit ? (CNT_W+1)'(count_increment) : '0);
        sum   = {1'b0, z_add} + {1'b0, o_add};
        halve = (sum >= (CNT_W+2)'(norm_limit));
        z_new = halve ? CNT_W'((z_add + (CNT_W+1)'(1)) >> 1) : z_add[CNT_W-1:0];
        o_new = halve ? CNT_W'((o_add + (CNT_W+1)'(1)) >> 1) : o_add[CNT_W-1:0];
        new_word = {o_new, z_new};
    end

    always_comb
    begin
        if (clr_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = b_fire && !b_flags_reg.err;
            ram_waddr = b_idx_reg;
            ram_wdata = {1'b1, new_word};
        end
    end

    agb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CONTEXTS)
    ) u_ctx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (a_fire),
        .raddr (q_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
                if (clr_cnt_reg == IW'(CONTEXTS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (a_fire)
            begin
                b_vld_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_vld_reg <= 1'b0;
            end
            if (b_fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!decision_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_flags_reg  <= q_flags;
            b_idx_reg    <= q_idx;
            // forward the word written in this cycle to the same context
            byp_hit_reg  <= b_fire && !b_flags_reg.err && (q_idx == b_idx_reg);
            byp_data_reg <= new_word;
        end
        if (b_fire)
        begin
            decision_bit  <= b_flags_reg.err ? 1'b0 : b_flags_reg.dbit;
            zero_count    <= b_flags_reg.err ? '0 : cur_z;
            one_count     <= b_flags_reg.err ? '0 : cur_o;
            last_decision <= b_flags_reg.last;
            range_error   <= b_flags_reg.err;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_adaptive_gamma_binarizer.sv -----
// ============================================================================
// tb_adaptive_gamma_binarizer
// Self-checking bench for the binarizer. Signed values go in over the value
// channel; a local model of the context store works out every decision with
// its pre-update counts, and each retired decision is compared field by field.
// A short directed table runs first, then random values under several
// register settings, with random gaps and stalls on both channels.
// ============================================================================
module tb_adaptive_gamma_binarizer;
    import agb_pkg::*;

    localparam int MAX_LEN          = 8;
    localparam int CONTEXTS         = 2048;
    localparam int IDLE_LIMIT       = 12000;  // clearing pass plus long stalls, many times over
    localparam int RANDOM_PER_PHASE = 80;
    localparam int PHASES           = 5;
    localparam int TAIL_CYCLES      = 20;     // a few times the decision latency
    localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, the block drops writes here

    // One decision as it leaves the block.
    typedef struct packed {
        logic             dbit;
        logic [CNT_W-1:0] zeros;
        logic [CNT_W-1:0] ones;
        logic             last;
        logic             err;
    } decision_t;

    // One row of the directed table; a pinned row also carries its first decision.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      pinned;
        decision_t                 first;
    } directed_row_t;

    localparam decision_t NO_DECISION  = '0;
    localparam decision_t OUT_OF_RANGE = '{dbit: 1'b0, zeros: '0, ones: '0,
                                           last: 1'b1, err: 1'b1};

    localparam int DIRECTED_ROWS = 20;

    // Directed values: sign and length extremes, the first magnitudes past
    // MAX_LEN, the longest prefix, and repeats that show the counts growing.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // fresh root right after reset: both counts at the reset initial count
        '{16'sd0,      1'b1, '{1'b0, 16'd1, 16'd1, 1'b0, 1'b0}},
        // root again, after one zero decision
        '{-16'sd1,     1'b1, '{1'b1, 16'd2, 16'd1, 1'b0, 1'b0}},
        '{16'sd1,      1'b0, NO_DECISION},
        '{-16'sd2,     1'b0, NO_DECISION},
        '{16'sd2,      1'b0, NO_DECISION},
        '{16'sh7FFF,   1'b1, OUT_OF_RANGE},  // largest positive value
        '{16'sh8000,   1'b1, OUT_OF_RANGE},  // most negative value
        '{16'sd511,    1'b1, OUT_OF_RANGE},  // first length past MAX_LEN
        '{-16'sd512,   1'b1, OUT_OF_RANGE},  // same on the negative side
        '{16'sd510,    1'b0, NO_DECISION},   // longest legal prefix
        '{-16'sd511,   1'b0, NO_DECISION},
        '{16'sd255,    1'b0, NO_DECISION},
        '{16'sd256,    1'b0, NO_DECISION},
        '{-16'sd256,   1'b0, NO_DECISION},
        '{16'sd170,    1'b0, NO_DECISION},   // suffix bits mostly alternating
        '{-16'sd171,   1'b0, NO_DECISION},
        '{16'sd0,      1'b0, NO_DECISION},
        '{16'sd0,      1'b0, NO_DECISION},
        '{16'sd510,    1'b0, NO_DECISION},
        '{-16'sd2,     1'b0, NO_DECISION}
    };

    // Register settings per random phase: the ends of each range and values
    // outside it, which the block uses as written.
    localparam int unsigned PHASE_INCREMENT [PHASES] = '{255, 1,   0, 1,  37};
    localparam int unsigned PHASE_NORM      [PHASES] = '{65535, 2, 0, 1, 300};
    localparam int unsigned PHASE_INIT      [PHASES] = '{255, 1,   0, 1, 200};

    logic clk = 1'b0;
    logic rst_n;

    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    logic                      value_valid;
    logic                      value_stall;
    logic signed [VALUE_W-1:0] value;

    logic                      decision_valid;
    logic                      decision_stall;
    logic                      decision_bit;
    logic [CNT_W-1:0]          zero_count;
    logic [CNT_W-1:0]          one_count;
    logic                      last_decision;
    logic                      range_error;

    // Side band of the value driver: a pinned first decision for directed rows.
    logic                      row_pinned;
    decision_t                 row_first;

    // Context store as the bench sees it.
    bit [CNT_W-1:0] ctx_zeros [CONTEXTS];
    bit [CNT_W-1:0] ctx_ones  [CONTEXTS];
    bit             ctx_live  [CONTEXTS];

    // Register copies, at their reset values.
    int unsigned step_amount = 1;
    int unsigned halve_limit = 256;
    int unsigned seed_count  = 1;

    decision_t batch[$];              // decisions of the value being binarized
    decision_t pending_decisions[$];  // decisions still owed by the block

    int  mismatches  = 0;
    int  retired     = 0;
    int  idle_cycles = 0;
    bit  calm        = 1'b0;          // suppress gaps and stalls while set

    adaptive_gamma_binarizer #(
        .MAX_LEN  (MAX_LEN),
        .CONTEXTS (CONTEXTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .value_valid    (value_valid),
        .value_stall    (value_stall),
        .value          (value),
        .decision_valid (decision_valid),
        .decision_stall (decision_stall),
        .decision_bit   (decision_bit),
        .zero_count     (zero_count),
        .one_count      (one_count),
        .last_decision  (last_decision),
        .range_error    (range_error)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Print one line per mismatch and count it; keep the log short.
    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] decision %0d: %s is %0h, expected %0h",
                     $time, retired, field, got, want);
    endtask

    // Gap length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // Code one decision through its context: record the counts as they stand,
    // then bump the coded bit's count and halve both once the sum hits the limit.
    function automatic void code_decision(int unsigned node, bit b, bit last);
        int unsigned slot;
        int unsigned z;
        int unsigned o;
        decision_t   d;
        slot = node % CONTEXTS;
        if (!ctx_live[slot])
        begin
            ctx_zeros[slot] = seed_count[CNT_W-1:0];
            ctx_ones[slot]  = seed_count[CNT_W-1:0];
            ctx_live[slot]  = 1'b1;
        end
        z = ctx_zeros[slot];
        o = ctx_ones[slot];
        d.dbit  = b;
        d.zeros = z[CNT_W-1:0];
        d.ones  = o[CNT_W-1:0];
        d.last  = last;
        d.err   = 1'b0;
        batch.push_back(d);
        if (b)
            o += step_amount;
        else
            z += step_amount;
        if (z + o >= halve_limit)
        begin
            z = (z + 1) / 2;
            o = (o + 1) / 2;
        end
        ctx_zeros[slot] = z[CNT_W-1:0];
        ctx_ones[slot]  = o[CNT_W-1:0];
    endfunction

    // Binarize one value into batch: sign, unary length, then suffix bits
    // MSB first, each through its node of the path tree.
    function automatic void binarize(logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] raw;
        logic [VALUE_W-1:0] folded;
        bit                 neg;
        bit                 b;
        int unsigned        mag;
        int unsigned        span;
        int unsigned        len;
        int unsigned        base;
        int unsigned        suffix_base;
        int unsigned        offset;
        int unsigned        path;
        batch.delete();
        raw    = v;
        neg    = raw[VALUE_W-1];
        folded = neg ? ~raw : raw;
        mag    = folded;
        span   = mag + 1;
        len    = 0;
        while (span > 1)
        begin
            span >>= 1;
            len++;
        end
        if (len > MAX_LEN)
        begin
            // too long to code: one flagged decision, contexts untouched
            batch.push_back(OUT_OF_RANGE);
            return;
        end
        code_decision(0, neg, 1'b0);
        base = 1 + (neg ? (2 ** (MAX_LEN + 1) - 1) : 0);
        for (int k = 0; k < len; k++)
            code_decision(base + k, 1'b0, 1'b0);
        code_decision(base + len, 1'b1, len == 0);
        suffix_base = base + MAX_LEN + 1 + ((1 << len) - 1 - len);
        offset      = mag - ((1 << len) - 1);
        path        = 0;
        for (int depth = 0; depth < len; depth++)
        begin
            b = 1'((offset >> (len - 1 - depth)) & 1);
            code_decision(suffix_base + (1 << depth) - 1 + path, b, depth + 1 == len);
            path = (path << 1) | b;
        end
    endfunction

    // Random value: mostly legal lengths with random suffix and sign, some
    // magnitudes past MAX_LEN, some raw 16-bit patterns.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int                 roll;
        int unsigned        len;
        logic [VALUE_W-1:0] mag;
        roll = $urandom_range(99);
        if (roll < 12)
            return VALUE_W'($urandom());
        if (roll < 22)
            mag = VALUE_W'((1 << (MAX_LEN + 1)) - 1 +
                  ($urandom_range(1) ? $urandom_range(2) : $urandom_range(32256)));
        else
        begin
            len = $urandom_range(MAX_LEN);
            mag = VALUE_W'((1 << len) - 1 + $urandom_range((1 << len) - 1));
        end
        return $urandom_range(1) ? ~mag : mag;
    endfunction

    // Offer one value after a random gap; hold it until the block takes it.
    task automatic offer_value(logic signed [VALUE_W-1:0] v, logic pin, decision_t first);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            value_valid <= 1'b0;
        end
        @(negedge clk);
        value_valid <= 1'b1;
        value       <= v;
        row_pinned  <= pin;
        row_first   <= first;
        do
            @(posedge clk);
        while (value_stall);
    endtask

    // Drop valid and wait until every owed decision has retired.
    task automatic settle();
        @(negedge clk);
        value_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(logic [1:0] reg_index, logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (reg_index)
            REG_INCREMENT: step_amount = data[INC_W-1:0];
            REG_NORM:      halve_limit = data[NORM_W-1:0];
            REG_INIT:      seed_count  = data[INIT_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Value side: every accepted value adds its decisions to the owed list.
    // A pinned directed row replaces the first one with the typed-in decision.
    always @(posedge clk)
    begin
        if (rst_n && value_valid && !value_stall)
        begin
            binarize(value);
            if (row_pinned)
                batch[0] = row_first;
            foreach (batch[i])
                pending_decisions.push_back(batch[i]);
        end
    end

    // Decision side: compare each retired decision with the oldest owed one.
    always @(posedge clk)
    begin
        decision_t owed;
        if (rst_n && decision_valid && !decision_stall)
        begin
            if (pending_decisions.size() == 0)
                report_mismatch("decision with none owed",
                                {decision_bit, zero_count, one_count,
                                 last_decision, range_error}, 0);
            else
            begin
                owed = pending_decisions.pop_front();
                if (decision_bit !== owed.dbit)
                    report_mismatch("decision_bit", decision_bit, owed.dbit);
                if (zero_count !== owed.zeros)
                    report_mismatch("zero_count", zero_count, owed.zeros);
                if (one_count !== owed.ones)
                    report_mismatch("one_count", one_count, owed.ones);
                if (last_decision !== owed.last)
                    report_mismatch("last_decision", last_decision, owed.last);
                if (range_error !== owed.err)
                    report_mismatch("range_error", range_error, owed.err);
            end
            retired++;
        end
    end

    // Receiver stalls: random stretches, none while calm.
    initial
    begin
        int hold;
        decision_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                decision_stall <= 1'b1;
                hold--;
            end
            else
            begin
                decision_stall <= 1'b0;
                hold = pick_gap();
            end
        end
    end

    // Watchdog: end the run after too long without any handshake.
    always @(posedge clk)
    begin
        if ((value_valid && !value_stall) || (decision_valid && !decision_stall) ||
            (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        value_valid = 1'b0;
        value       = '0;
        row_pinned  = 1'b0;
        row_first   = NO_DECISION;

        // Hold reset, then release it on a falling edge. The clearing
        // pass that follows shows up as value_stall, so just wait it out.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table at the reset register values.
        foreach (directed_rows[i])
            offer_value(directed_rows[i].value, directed_rows[i].pinned,
                        directed_rows[i].first);
        settle();

        // Random phases; registers change only once the block has drained.
        // Upper data bits are random to show they are dropped.
        for (int p = 0; p < PHASES; p++)
        begin
            write_register(REG_INCREMENT, ($urandom() & ~32'hFF) | PHASE_INCREMENT[p]);
            write_register(REG_NORM, ($urandom() & ~32'hFFFF) | PHASE_NORM[p]);
            // unmapped index: must leave every setting alone
            if (p == PHASES - 1)
                write_register(REG_SPARE, $urandom());
            write_register(REG_INIT, ($urandom() & ~32'hFF) | PHASE_INIT[p]);
            calm = (p == 1);
            repeat (RANDOM_PER_PHASE)
            begin
                // flip between idling and full-rate stretches now and then
                if ($urandom_range(15) == 0)
                    calm = !calm;
                offer_value(random_value(), 1'b0, NO_DECISION);
            end
            settle();
            calm = 1'b0;
        end

        // Let any stray decision show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
